// ===== rtl/euler_to_quaternion_assert.svh =====
// assertion macros for the euler to quaternion block
`ifndef EULER_TO_QUATERNION_ASSERT_SVH
`define EULER_TO_QUATERNION_ASSERT_SVH

// implication checked at every clock, disabled in reset
`define E2Q_ASSERT_IMP(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");

// next-cycle implication
`define E2Q_ASSERT_NEXT(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");

`endif

// ===== rtl/e2q_pkg.sv =====
// ----------------------------------------------------------------------------
// e2q_pkg
// shared constants and helpers for the euler to quaternion block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package e2q_pkg;

  localparam int ANGLE_WIDTH_DEF   = 16;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int QW                = 16;

  // cordic datapath width, q.30 with headroom
  localparam int CW = 34;

  localparam logic signed [CW-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [CW-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [CW-1:0] KINF_Q30    = 34'sd652032874;
  localparam logic signed [17:0]   ONE_Q14     = 18'sd16384;

  // lane state handed from cell to cell
  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic                 neg;
  } lane_t;

  function automatic logic signed [CW-1:0] atan_q30(input int i);
    logic signed [CW-1:0] r;
    case (i)
      0: r = 34'sd843314857;
      1: r = 34'sd497837829;
      2: r = 34'sd263043837;
      3: r = 34'sd133525159;
      4: r = 34'sd67021687;
      5: r = 34'sd33543516;
      6: r = 34'sd16775851;
      7: r = 34'sd8388437;
      8: r = 34'sd4194283;
      9: r = 34'sd2097149;
      default: r = CW'(34'sd1073741824 >>> i);
    endcase
    return r;
  endfunction

  // cordic start value for n stages
  function automatic logic signed [CW-1:0] k_start(input int n);
    logic signed [CW-1:0] t;
    t = CW'(((KINF_Q30 * 2) / 3) >>> (2 * n));
    return KINF_Q30 + t;
  endfunction

endpackage

// ===== rtl/e2q_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// e2q_cordic_cell
// one cordic rotation stage for three lanes, registered
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module e2q_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic                 clk,
  input  logic                 en,
  input  e2q_pkg::lane_t [2:0] lane_in,
  output e2q_pkg::lane_t [2:0] lane_out
);

  localparam logic signed [e2q_pkg::CW-1:0] ATAN = e2q_pkg::atan_q30(STAGE);

  e2q_pkg::lane_t [2:0] lane_next;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      lane_next[l].neg = lane_in[l].neg;
      if (!lane_in[l].z[e2q_pkg::CW-1]) begin
        lane_next[l].x = lane_in[l].x - (lane_in[l].y >>> STAGE);
        lane_next[l].y = lane_in[l].y + (lane_in[l].x >>> STAGE);
        lane_next[l].z = lane_in[l].z - ATAN;
      end else begin
        lane_next[l].x = lane_in[l].x + (lane_in[l].y >>> STAGE);
        lane_next[l].y = lane_in[l].y - (lane_in[l].x >>> STAGE);
        lane_next[l].z = lane_in[l].z + ATAN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane_out <= lane_next;
    end
  end

endmodule

// ===== rtl/euler_to_quaternion.sv =====
// ----------------------------------------------------------------------------
// euler_to_quaternion
// zyx euler angles to quaternion, pipelined cordic chain and product stages
// ----------------------------------------------------------------------------
// path: an input transaction passes the fold register, cordic cells, p1, p2, p3, output
// throughput: one transaction per cycle; the pipeline advances whenever the
// output register is empty or being taken, one cordic cell per iteration
// reset: rst clears all valid bits, payload registers are not reset
`timescale 1ns / 1ps
`include "euler_to_quaternion_assert.svh"

module euler_to_quaternion #(
  parameter int ANGLE_WIDTH   = e2q_pkg::ANGLE_WIDTH_DEF,
  parameter int CORDIC_STAGES = e2q_pkg::CORDIC_STAGES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [ANGLE_WIDTH-1:0] angle_x,
  input  logic signed [ANGLE_WIDTH-1:0] angle_y,
  input  logic signed [ANGLE_WIDTH-1:0] angle_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [e2q_pkg::QW-1:0] quat_x,
  output logic signed [e2q_pkg::QW-1:0] quat_y,
  output logic signed [e2q_pkg::QW-1:0] quat_z,
  output logic signed [e2q_pkg::QW-1:0] quat_w
);

  localparam int CW = e2q_pkg::CW;
  // stages: fold(1) + cells + p1 + p2 + p3 + round into out(1)
  localparam int NV = CORDIC_STAGES + 5;

  // whole pipe moves together; bubbles drain when the output is free
  logic adv;
  logic [NV-1:0] vld;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // ---- stage 0: halve angle into q.30 and fold into +-pi/2
  e2q_pkg::lane_t [2:0] fold_lane;
  e2q_pkg::lane_t [2:0] chain [CORDIC_STAGES+1];
  logic signed [ANGLE_WIDTH-1:0] ang [3];

  assign ang[0] = angle_x;
  assign ang[1] = angle_y;
  assign ang[2] = angle_z;

  always_comb begin
    logic signed [CW-1:0] t;
    for (int l = 0; l < 3; l++) begin
      // angle q.(w-3) halved equals q.(w-2); scale to q.30
      t = CW'(ang[l]) <<< (32 - ANGLE_WIDTH);
      fold_lane[l].neg = 1'b0;
      if (t > e2q_pkg::HALF_PI_Q30) begin
        t = t - e2q_pkg::PI_Q30;
        fold_lane[l].neg = 1'b1;
      end else if (t < -e2q_pkg::HALF_PI_Q30) begin
        t = t + e2q_pkg::PI_Q30;
        fold_lane[l].neg = 1'b1;
      end
      fold_lane[l].x = e2q_pkg::k_start(CORDIC_STAGES);
      fold_lane[l].y = '0;
      fold_lane[l].z = t;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      chain[0] <= fold_lane;
    end
  end

  // ---- cordic chain, one cell per iteration
  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    e2q_cordic_cell #(.STAGE(g)) u_cell (
      .clk      (clk),
      .en       (adv),
      .lane_in  (chain[g]),
      .lane_out (chain[g+1])
    );
  end

  // ---- sine/cosine with sign fix
  logic signed [CW-1:0] sn [3];
  logic signed [CW-1:0] cs [3];
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      sn[l] = chain[CORDIC_STAGES][l].neg ? -chain[CORDIC_STAGES][l].y
                                          :  chain[CORDIC_STAGES][l].y;
      cs[l] = chain[CORDIC_STAGES][l].neg ? -chain[CORDIC_STAGES][l].x
                                          :  chain[CORDIC_STAGES][l].x;
    end
  end

  // ---- p1: eight pair products a*b with carried third factor
  // terms: 0 sx cy cz, 1 cx sy sz, 2 cx sy cz, 3 sx cy sz,
  //        4 cx cy sz, 5 sx sy cz, 6 cx cy cz, 7 sx sy sz
  logic signed [2*CW-1:0] pab [8];
  logic signed [CW-1:0]   pc  [8];
  logic signed [CW-1:0]   fa [8], fb [8], fc [8];
  always_comb begin
    fa[0] = sn[0]; fb[0] = cs[1]; fc[0] = cs[2];
    fa[1] = cs[0]; fb[1] = sn[1]; fc[1] = sn[2];
    fa[2] = cs[0]; fb[2] = sn[1]; fc[2] = cs[2];
    fa[3] = sn[0]; fb[3] = cs[1]; fc[3] = sn[2];
    fa[4] = cs[0]; fb[4] = cs[1]; fc[4] = sn[2];
    fa[5] = sn[0]; fb[5] = sn[1]; fc[5] = cs[2];
    fa[6] = cs[0]; fb[6] = cs[1]; fc[6] = cs[2];
    fa[7] = sn[0]; fb[7] = sn[1]; fc[7] = sn[2];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 8; k++) begin
        pab[k] <= fa[k] * fb[k];
        pc[k]  <= fc[k];
      end
    end
  end

  // ---- p2: floor shift by 30 then multiply by third factor
  logic signed [2*CW-1:0] p3 [8];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 8; k++) begin
        p3[k] <= CW'(pab[k] >>> 30) * pc[k];
      end
    end
  end

  // ---- p3: combine pairs in q.60
  logic signed [2*CW-1:0] sum [4];
  always_ff @(posedge clk) begin
    if (adv) begin
      sum[0] <= p3[0] - p3[1];
      sum[1] <= p3[2] + p3[3];
      sum[2] <= p3[4] - p3[5];
      sum[3] <= p3[6] + p3[7];
    end
  end

  // ---- round half up to q.14 and saturate
  logic signed [e2q_pkg::QW-1:0] qn [4];
  always_comb begin
    logic signed [2*CW-1:0] r;
    for (int k = 0; k < 4; k++) begin
      r = (sum[k] + (68'sd1 <<< 45)) >>> 46;
      if (r > 68'(e2q_pkg::ONE_Q14)) begin
        qn[k] = e2q_pkg::QW'(e2q_pkg::ONE_Q14);
      end else if (r < -68'(e2q_pkg::ONE_Q14)) begin
        qn[k] = -e2q_pkg::QW'(e2q_pkg::ONE_Q14);
      end else begin
        qn[k] = e2q_pkg::QW'(r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      quat_x <= qn[0];
      quat_y <= qn[1];
      quat_z <= qn[2];
      quat_w <= qn[3];
    end
  end

  // ---- valid pipe, last bit is the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NV-2:0], in_valid};
    end
  end
  assign out_valid = vld[NV-1];

  // ---- checks
  `E2Q_ASSERT_IMP(a_stall_only_full, in_stall, out_valid && out_stall)
  `E2Q_ASSERT_NEXT(a_hold_stalled, out_valid && out_stall, out_valid)
  `E2Q_ASSERT_IMP(a_range_w, out_valid, quat_w <= 16'sd16384 && quat_w >= -16'sd16384)

endmodule
